@@ src/two_way_hash_tag_cache_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Two-way hash tag cache: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_HASH_TAG_CACHE_UNIT_DEFINES_SVH
`define TWO_WAY_HASH_TAG_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TWHTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twhtc: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TWHTC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twhtc: next-cycle check failed");

`endif

@@ src/twhtc_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-way hash tag cache package
// Row layout, configuration bundle, register indexes and LFSR constants.
// ----------------------------------------------------------------------------
package twhtc_pkg;

    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED      = CFG_IDX_W'(1);

    localparam logic [TAG_W-1:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [TAG_W-1:0] SEED_RESET = 32'h0000_0001;

    // One row of the tag store: hint names the preferred victim way
    typedef struct packed {
        logic             hint;
        logic [TAG_W-1:0] tag1;
        logic [TAG_W-1:0] tag0;
    } t_row;

    typedef struct packed {
        logic                 mode;
        logic                 seed_load;
        logic [CFG_DAT_W-1:0] seed;
    } t_cfg;

endpackage

@@ src/two_way_hash_tag_cache_unit.sv @@
// ----------------------------------------------------------------------------
// Two-way hash tag cache unit
// Result: registered as the lookup ends, held back while a stalled output
// still holds the last one. A new transaction waits until the read-then-write-back
// of the last row through the single-port-pair row memory is done.
// Reset: synchronous; a clearing pass over 2**clog2(ROW_COUNT) rows (4096 by
// default) zeroes every row, with input stalled and configuration still taken.
// ----------------------------------------------------------------------------
module two_way_hash_tag_cache_unit #(
    parameter int ROW_COUNT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [twhtc_pkg::TAG_W-1:0]     i_flow_hash,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic                            o_way,
    output logic [twhtc_pkg::CNT_W-1:0]     o_hit_total,
    output logic [twhtc_pkg::CNT_W-1:0]     o_miss_total,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [twhtc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [twhtc_pkg::CFG_DAT_W-1:0] i_cfg_wdata
);
    import twhtc_pkg::*;

    localparam int ADDR_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    logic              r_mode;
    logic              w_cfg_wr;
    t_cfg              w_cfg;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    t_row              w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    t_row              w_rd_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (w_cfg_wr && (i_cfg_index == REG_REPLACEMENT_MODE)) begin
            r_mode <= i_cfg_wdata[0];
        end
    end

    assign w_cfg.mode      = r_mode;
    assign w_cfg.seed_load = w_cfg_wr && (i_cfg_index == REG_RANDOM_SEED);
    assign w_cfg.seed      = i_cfg_wdata;

    twhtc_engine #(
        .ADDR_W (ADDR_W)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_flow_hash   (i_flow_hash),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_way         (o_way),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_ram_wr_en   (w_wr_en),
        .o_ram_wr_addr (w_wr_addr),
        .o_ram_wr_data (w_wr_data),
        .o_ram_rd_en   (w_rd_en),
        .o_ram_rd_addr (w_rd_addr),
        .i_ram_rd_data (w_rd_data)
    );

    twhtc_row_ram #(
        .ADDR_W (ADDR_W)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

@@ src/twhtc_row_ram.sv @@
// ----------------------------------------------------------------------------
// Tag row memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module twhtc_row_ram #(
    parameter int ADDR_W = 12
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  twhtc_pkg::t_row    i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output twhtc_pkg::t_row    o_rd_data
);
    import twhtc_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    t_row r_mem [DEPTH];
    t_row r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/twhtc_engine.sv @@
// ----------------------------------------------------------------------------
// Lookup engine
// Clears the row memory, then reads a row per transaction, compares both
// tags, picks a victim, writes the row back and registers the result.
// ----------------------------------------------------------------------------
module twhtc_engine #(
    parameter int ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  twhtc_pkg::t_cfg             i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [twhtc_pkg::TAG_W-1:0] i_flow_hash,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic                        o_way,
    output logic [twhtc_pkg::CNT_W-1:0] o_hit_total,
    output logic [twhtc_pkg::CNT_W-1:0] o_miss_total,
    output logic                        o_ram_wr_en,
    output logic [ADDR_W-1:0]           o_ram_wr_addr,
    output twhtc_pkg::t_row             o_ram_wr_data,
    output logic                        o_ram_rd_en,
    output logic [ADDR_W-1:0]           o_ram_rd_addr,
    input  twhtc_pkg::t_row             i_ram_rd_data
);
    import twhtc_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state             r_state,     n_state;
    logic [ADDR_W-1:0]  r_clr_addr,  n_clr_addr;
    logic [TAG_W-1:0]   r_hash,      n_hash;
    logic [TAG_W-1:0]   r_lfsr,      n_lfsr;
    logic [CNT_W-1:0]   r_hit_cnt,   n_hit_cnt;
    logic [CNT_W-1:0]   r_miss_cnt,  n_miss_cnt;
    logic               r_out_valid, n_out_valid;
    logic               r_hit,       n_hit;
    logic               r_way,       n_way;

    logic               w_hit0;
    logic               w_hit1;
    logic               w_hit;
    logic               w_way;
    logic               w_done;
    t_row               w_row;
    logic [TAG_W-1:0]   w_lfsr_step;

    assign w_hit0 = (i_ram_rd_data.tag0 == r_hash);
    assign w_hit1 = (i_ram_rd_data.tag1 == r_hash);
    assign w_hit  = w_hit0 | w_hit1;

    // Way 0 wins when both tags match
    always_comb begin
        if (w_hit0) begin
            w_way = 1'b0;
        end else if (w_hit1) begin
            w_way = 1'b1;
        end else if (i_cfg.mode) begin
            w_way = i_ram_rd_data.hint;
        end else begin
            w_way = r_lfsr[0];
        end
    end

    always_comb begin
        w_row = i_ram_rd_data;
        if (!w_hit) begin
            if (w_way) begin
                w_row.tag1 = r_hash;
            end else begin
                w_row.tag0 = r_hash;
            end
        end
        w_row.hint = ~w_way;
    end

    assign w_lfsr_step = {1'b0, r_lfsr[TAG_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);

    // Finish the lookup once the output register is free or being emptied
    assign w_done = (r_state == S_LOOKUP) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_hash        = r_hash;
        n_lfsr        = r_lfsr;
        n_hit_cnt     = r_hit_cnt;
        n_miss_cnt    = r_miss_cnt;
        n_hit         = r_hit;
        n_way         = r_way;
        n_out_valid   = r_out_valid && i_out_stall;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_hash[ADDR_W-1:0];
        o_ram_wr_data = w_row;
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = i_flow_hash[ADDR_W-1:0];

        case (r_state)
            S_CLEAR: begin
                o_ram_wr_en   = 1'b1;
                o_ram_wr_addr = r_clr_addr;
                o_ram_wr_data = '0;
                n_clr_addr    = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ram_rd_en = 1'b1;
                    n_hash      = i_flow_hash;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (w_done) begin
                    o_ram_wr_en = 1'b1;
                    n_hit       = w_hit;
                    n_way       = w_way;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (w_hit) begin
                        n_hit_cnt = r_hit_cnt + 1'b1;
                    end else begin
                        n_miss_cnt = r_miss_cnt + 1'b1;
                        if (!i_cfg.mode) begin
                            n_lfsr = w_lfsr_step;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A zero seed would lock the LFSR: load it as one
        if (i_cfg.seed_load) begin
            n_lfsr = (i_cfg.seed != '0) ? i_cfg.seed : SEED_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_lfsr      <= SEED_RESET;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_lfsr      <= n_lfsr;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_out_valid <= n_out_valid;
        end
        r_hash <= n_hash;
        r_hit  <= n_hit;
        r_way  <= n_way;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_way        = r_way;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

endmodule

@@ src/twhtc_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the two-way hash tag cache unit
// Watches the handshakes and the running hit and miss totals.
// ----------------------------------------------------------------------------
`include "two_way_hash_tag_cache_unit_defines.svh"

module twhtc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            o_hit,
    input  logic                            o_way,
    input  logic [twhtc_pkg::CNT_W-1:0]     o_hit_total,
    input  logic [twhtc_pkg::CNT_W-1:0]     o_miss_total
);
    import twhtc_pkg::*;

    logic               w_in_acc;
    logic               w_out_acc;
    logic [2*CNT_W+1:0] w_out_bus;
    logic [CNT_W-1:0]   r_last_hit;
    logic [CNT_W-1:0]   r_last_miss;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_out_bus = {o_hit, o_way, o_hit_total, o_miss_total};

    // Track the totals of the last delivered transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hit  <= '0;
            r_last_miss <= '0;
        end else if (w_out_acc) begin
            r_last_hit  <= o_hit_total;
            r_last_miss <= o_miss_total;
        end
    end

    `TWHTC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(w_out_bus))

    `TWHTC_ASSERT_NXT(a_one_in_flight, w_in_acc, o_in_stall)

    `TWHTC_ASSERT_IMP(a_hit_step, w_out_acc, o_hit_total == (r_last_hit + CNT_W'(o_hit)))

    `TWHTC_ASSERT_IMP(a_miss_step, w_out_acc, o_miss_total == (r_last_miss + CNT_W'(!o_hit)))

endmodule

bind two_way_hash_tag_cache_unit twhtc_checker u_twhtc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hit        (o_hit),
    .o_way        (o_way),
    .o_hit_total  (o_hit_total),
    .o_miss_total (o_miss_total)
);
